// File: rtl/ptw_pkg.sv
// ----------------------------------------------------------------------------
// ptw_pkg
// Shared types, constants and codes of the two-level page table walker.
// ----------------------------------------------------------------------------
package ptw_pkg;

  localparam int unsigned STORE_WORDS            = 65536;
  localparam int unsigned USER_DIRECTORY_ENTRIES = 768;
  localparam int unsigned ADDR_W                 = $clog2(STORE_WORDS);
  localparam int unsigned WIDX_W                 = 30;
  localparam int unsigned CLR_W                  = 10;
  localparam int unsigned PADDR_W                = 3;

  localparam logic [WIDX_W-1:0] STORE_LIMIT = WIDX_W'(STORE_WORDS);
  localparam logic [10:0]       USER_LIMIT  = 11'(USER_DIRECTORY_ENTRIES);

  localparam logic [1:0] OP_LOOKUP = 2'd0;
  localparam logic [1:0] OP_MAP    = 2'd1;
  localparam logic [1:0] OP_WRITE  = 2'd2;
  localparam logic [1:0] OP_READ   = 2'd3;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_NOT_MAPPED = 3'd1;
  localparam logic [2:0] ST_KERNEL     = 3'd2;
  localparam logic [2:0] ST_NO_SPARE   = 3'd3;
  localparam logic [2:0] ST_OUTSIDE    = 3'd4;

  localparam logic [11:0] PDE_NEW_FLAGS = 12'h007;
  localparam logic [11:0] PTE_FLAGS     = 12'h005;

  typedef struct packed {
    logic [1:0]  operation;
    logic [31:0] virtual_address;
    logic [31:0] physical_address;
    logic [11:0] page_flags;
    logic [31:0] spare_table_frame;
    logic [31:0] write_word;
  } req_t;

  typedef struct packed {
    logic [31:0] translated_address;
    logic [31:0] read_word;
    logic [2:0]  status;
  } rsp_t;

  typedef enum logic [2:0] {
    ADDR_PDE,
    ADDR_PTE,
    ADDR_CLEAR,
    ADDR_SPARE_PTE,
    ADDR_WORD
  } addr_sel_e;

  typedef enum logic [1:0] {
    DATA_ZERO,
    DATA_PDE_NEW,
    DATA_PTE,
    DATA_WORD
  } data_sel_e;

  typedef enum logic [1:0] {
    RSP_NONE,
    RSP_LARGE,
    RSP_PTE,
    RSP_WORD
  } rsp_sel_e;

  typedef struct packed {
    logic      load_req;
    logic      mem_we;
    logic      mem_re;
    addr_sel_e addr_sel;
    data_sel_e data_sel;
    logic      clr_inc;
    logic      load_rsp;
    rsp_sel_e  rsp_sel;
    logic [2:0] status;
  } cmd_t;

  typedef struct packed {
    logic [1:0] operation;
    logic       kernel;
    logic       pde_out;
    logic       entry_present;
    logic       entry_large;
    logic       pte_out;
    logic       spare_zero;
    logic       spare_out;
    logic       word_out;
    logic       clr_last;
  } sts_t;

endpackage

// File: rtl/ptw_datapath.sv
// ----------------------------------------------------------------------------
// ptw_datapath
// Table store, request and read registers, address generation, range checks
// and the response register of the page table walker.
// ----------------------------------------------------------------------------
module ptw_datapath import ptw_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [31:0] dir_base_i,
  input  req_t        req_i,
  input  cmd_t        cmd_i,
  output sts_t        sts_o,
  output rsp_t        rsp_o
);

  logic [31:0]       mem [STORE_WORDS];
  req_t              req_q;
  logic [31:0]       rdata_q;
  rsp_t              rsp_q;
  logic [CLR_W-1:0]  clr_cnt_q;
  logic [CLR_W-1:0]  clr_cnt_d;

  logic [WIDX_W-1:0] pde_w;
  logic [WIDX_W-1:0] pte_w;
  logic [WIDX_W-1:0] spare_end_w;
  logic [WIDX_W-1:0] spare_pte_w;
  logic [WIDX_W-1:0] clear_w;
  logic [WIDX_W-1:0] word_w;
  logic [WIDX_W-1:0] sel_w;
  logic [31:0]       pte_val;
  logic [31:0]       wdata;

  assign pde_w       = {dir_base_i[31:12], req_q.virtual_address[31:22]};
  assign pte_w       = {rdata_q[31:12], req_q.virtual_address[21:12]};
  assign spare_end_w = {req_q.spare_table_frame[31:12], {CLR_W{1'b1}}};
  assign spare_pte_w = {req_q.spare_table_frame[31:12], req_q.virtual_address[21:12]};
  assign clear_w     = {req_q.spare_table_frame[31:12], clr_cnt_q};
  assign word_w      = req_q.physical_address[31:2];
  assign pte_val     = {req_q.physical_address[31:12], 12'h000}
                     | {20'h00000, req_q.page_flags}
                     | {20'h00000, PTE_FLAGS};

  always_comb begin
    case (cmd_i.addr_sel)
      ADDR_PDE:       sel_w = pde_w;
      ADDR_PTE:       sel_w = pte_w;
      ADDR_CLEAR:     sel_w = clear_w;
      ADDR_SPARE_PTE: sel_w = spare_pte_w;
      ADDR_WORD:      sel_w = word_w;
      default:        sel_w = word_w;
    endcase
  end

  always_comb begin
    case (cmd_i.data_sel)
      DATA_ZERO:    wdata = 32'h0000_0000;
      DATA_PDE_NEW: wdata = {req_q.spare_table_frame[31:12], PDE_NEW_FLAGS};
      DATA_PTE:     wdata = pte_val;
      DATA_WORD:    wdata = req_q.write_word;
      default:      wdata = 32'h0000_0000;
    endcase
  end

  assign sts_o.operation     = req_q.operation;
  assign sts_o.kernel        = {1'b0, req_q.virtual_address[31:22]} >= USER_LIMIT;
  assign sts_o.pde_out       = pde_w >= STORE_LIMIT;
  assign sts_o.entry_present = rdata_q[0];
  assign sts_o.entry_large   = rdata_q[7];
  assign sts_o.pte_out       = pte_w >= STORE_LIMIT;
  assign sts_o.spare_zero    = req_q.spare_table_frame[31:12] == 20'h00000;
  assign sts_o.spare_out     = spare_end_w >= STORE_LIMIT;
  assign sts_o.word_out      = word_w >= STORE_LIMIT;
  assign sts_o.clr_last      = clr_cnt_q == {CLR_W{1'b1}};

  assign clr_cnt_d = clr_cnt_q + CLR_W'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (cmd_i.clr_inc) begin
      clr_cnt_q <= clr_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_we) begin
      mem[sel_w[ADDR_W-1:0]] <= wdata;
    end
    if (cmd_i.mem_re) begin
      rdata_q <= mem[sel_w[ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      req_q <= req_i;
    end
    if (cmd_i.load_rsp) begin
      rsp_q.status <= cmd_i.status;
      case (cmd_i.rsp_sel)
        RSP_LARGE: rsp_q.translated_address <= {rdata_q[31:22],
                                                req_q.virtual_address[21:0]};
        RSP_PTE:   rsp_q.translated_address <= {rdata_q[31:12], 12'h000};
        default:   rsp_q.translated_address <= 32'h0000_0000;
      endcase
      rsp_q.read_word <= (cmd_i.rsp_sel == RSP_WORD) ? rdata_q : 32'h0000_0000;
    end
  end

  assign rsp_o = rsp_q;

endmodule

// File: rtl/ptw_ctrl.sv
// ----------------------------------------------------------------------------
// ptw_ctrl
// Sequencer of the page table walker: request handshake, table walk, table
// clearing, entry and word accesses and the response handshake.
// ----------------------------------------------------------------------------
module ptw_ctrl import ptw_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  output logic out_valid_o,
  input  logic out_stall_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_FIRST,
    S_PDE,
    S_PTE,
    S_WORD,
    S_CLEAR,
    S_WR_PDE,
    S_WR_PTE
  } state_e;

  state_e state_q;
  state_e state_d;
  logic   out_valid_q;
  logic   out_free;
  logic   fin;
  cmd_t   cmd;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    cmd          = '0;
    cmd.addr_sel = ADDR_WORD;
    cmd.data_sel = DATA_ZERO;
    cmd.rsp_sel  = RSP_NONE;
    cmd.status   = ST_OK;
    fin          = 1'b0;
    state_d      = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd.load_req = 1'b1;
          state_d      = S_FIRST;
        end
      end
      S_FIRST: begin
        case (sts_i.operation)
          OP_LOOKUP: begin
            if (sts_i.pde_out) begin
              fin        = 1'b1;
              cmd.status = ST_OUTSIDE;
            end else begin
              cmd.mem_re   = 1'b1;
              cmd.addr_sel = ADDR_PDE;
              state_d      = S_PDE;
            end
          end
          OP_MAP: begin
            if (sts_i.kernel) begin
              fin        = 1'b1;
              cmd.status = ST_KERNEL;
            end else if (sts_i.pde_out) begin
              fin        = 1'b1;
              cmd.status = ST_OUTSIDE;
            end else begin
              cmd.mem_re   = 1'b1;
              cmd.addr_sel = ADDR_PDE;
              state_d      = S_PDE;
            end
          end
          OP_WRITE: begin
            fin = 1'b1;
            if (sts_i.word_out) begin
              cmd.status = ST_OUTSIDE;
            end else begin
              cmd.mem_we   = 1'b1;
              cmd.addr_sel = ADDR_WORD;
              cmd.data_sel = DATA_WORD;
            end
          end
          default: begin
            if (sts_i.word_out) begin
              fin        = 1'b1;
              cmd.status = ST_OUTSIDE;
            end else begin
              cmd.mem_re   = 1'b1;
              cmd.addr_sel = ADDR_WORD;
              state_d      = S_WORD;
            end
          end
        endcase
      end
      S_PDE: begin
        if (sts_i.operation == OP_LOOKUP) begin
          if (!sts_i.entry_present) begin
            fin        = 1'b1;
            cmd.status = ST_NOT_MAPPED;
          end else if (sts_i.entry_large) begin
            fin         = 1'b1;
            cmd.rsp_sel = RSP_LARGE;
          end else if (sts_i.pte_out) begin
            fin        = 1'b1;
            cmd.status = ST_OUTSIDE;
          end else begin
            cmd.mem_re   = 1'b1;
            cmd.addr_sel = ADDR_PTE;
            state_d      = S_PTE;
          end
        end else begin
          if (!sts_i.entry_present) begin
            if (sts_i.spare_zero) begin
              fin        = 1'b1;
              cmd.status = ST_NO_SPARE;
            end else if (sts_i.spare_out) begin
              fin        = 1'b1;
              cmd.status = ST_OUTSIDE;
            end else begin
              state_d = S_CLEAR;
            end
          end else if (sts_i.pte_out) begin
            fin        = 1'b1;
            cmd.status = ST_OUTSIDE;
          end else begin
            fin          = 1'b1;
            cmd.mem_we   = 1'b1;
            cmd.addr_sel = ADDR_PTE;
            cmd.data_sel = DATA_PTE;
          end
        end
      end
      S_PTE: begin
        fin = 1'b1;
        if (!sts_i.entry_present) begin
          cmd.status = ST_NOT_MAPPED;
        end else begin
          cmd.rsp_sel = RSP_PTE;
        end
      end
      S_WORD: begin
        fin         = 1'b1;
        cmd.rsp_sel = RSP_WORD;
      end
      S_CLEAR: begin
        cmd.mem_we   = 1'b1;
        cmd.addr_sel = ADDR_CLEAR;
        cmd.data_sel = DATA_ZERO;
        cmd.clr_inc  = 1'b1;
        if (sts_i.clr_last) begin
          state_d = S_WR_PDE;
        end
      end
      S_WR_PDE: begin
        cmd.mem_we   = 1'b1;
        cmd.addr_sel = ADDR_PDE;
        cmd.data_sel = DATA_PDE_NEW;
        state_d      = S_WR_PTE;
      end
      S_WR_PTE: begin
        fin          = 1'b1;
        cmd.mem_we   = 1'b1;
        cmd.addr_sel = ADDR_SPARE_PTE;
        cmd.data_sel = DATA_PTE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    // A finishing step repeats while the response register is still occupied.
    if (fin) begin
      if (out_free) begin
        cmd.load_rsp = 1'b1;
        state_d      = S_IDLE;
      end else begin
        state_d = state_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cmd.load_rsp) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign in_stall_o  = state_q != S_IDLE;
  assign out_valid_o = out_valid_q;
  assign cmd_o       = cmd;

`ifndef SYNTH
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> state_q == S_FIRST)
    else $error("accepted request did not start a walk");

  a_rsp_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_rsp |-> (!out_valid_q || !out_stall_i))
    else $error("response overwritten while stalled");

  a_one_port_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd.mem_we && cmd.mem_re))
    else $error("store read and write in one cycle");

  a_clear_to_pde: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR && sts_i.clr_last) |=> state_q == S_WR_PDE)
    else $error("table clear did not end in a directory write");

  a_rsp_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_rsp |=> out_valid_q)
    else $error("loaded response not presented");
`endif

endmodule

// File: rtl/two_level_page_table_walker.sv
// ----------------------------------------------------------------------------
// two_level_page_table_walker
// A word write finishes in its first step. A word read and a large-page lookup
// read the store once, a full lookup twice. A map reads the directory entry and
// writes the table entry, or for a new table clears 1024 words, one store write
// per cycle, then writes the directory and table entries. The next request is
// accepted in the cycle after the result is loaded. The single-ported table
// store sets these steps, and a stalled result holds the walker in its last step.
// Reset clears the sequencer, the clear counter and the directory base only;
// the table store is not cleared and holds undefined data until written.
// ----------------------------------------------------------------------------
module two_level_page_table_walker import ptw_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  req_t               in_req_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output rsp_t               out_rsp_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic [31:0] dir_base_q;
  cmd_t        cmd;
  sts_t        sts;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_base_q <= 32'h0000_0000;
    end else if (psel && penable && pwrite && pready && !paddr[2]) begin
      dir_base_q <= pwdata;
    end
  end

  assign prdata = paddr[2] ? 32'h0000_0000 : dir_base_q;

  ptw_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  ptw_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .dir_base_i (dir_base_q),
    .req_i      (in_req_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .rsp_o      (out_rsp_o)
  );

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the two-level page table walker. Requests of all
// four operations go in through the valid/stall channel. A table walk model
// kept in the bench predicts each response when its request is accepted. The
// same model, run without committing, steers the random requests away from
// reads of table words that nothing has written yet. The directory base is
// moved between phases over the APB port, while the walker is idle.
// ----------------------------------------------------------------------------
module tb_top;
  import ptw_pkg::*;

  localparam int unsigned CLK_PERIOD = 2;
  localparam longint unsigned TIMEOUT_NS = 20_000_000;
  localparam logic [PADDR_W-1:0] REG_DIRECTORY_BASE = PADDR_W'(0);
  localparam logic [31:0] FRAME_MASK        = 32'hFFFF_F000;
  localparam logic [31:0] LARGE_FRAME_MASK  = 32'hFFC0_0000;
  localparam logic [31:0] LARGE_OFFSET_MASK = 32'h003F_FFFF;
  localparam int unsigned TABLE_WORDS = 1024;
  localparam int unsigned ENTRY_PRESENT = 0;
  localparam int unsigned ENTRY_LARGE   = 7;
  localparam int unsigned MAX_TABLES    = 250;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic in_valid = 1'b0;
  logic in_stall_o;
  req_t in_req = '0;
  logic out_valid_o;
  logic out_stall = 1'b0;
  rsp_t out_rsp_o;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  bit [31:0] phys_mem [STORE_WORDS];
  bit mem_written [STORE_WORDS];
  logic [31:0] dir_base_q = '0;
  int unsigned tables_built = 0;

  req_t pending_req[$];
  rsp_t expected_rsp[$];
  logic [31:0] mapped_va[$];
  int unsigned requests_accepted;
  int unsigned failures = 0;
  int unsigned hold_cycles;
  bit hold_done;
  logic quiet;

  assign quiet = (requests_accepted >= 600) && (requests_accepted < 800);

  always #(CLK_PERIOD / 2.0) clk_i = ~clk_i;

  two_level_page_table_walker i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall),
    .out_rsp_o  (out_rsp_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  function automatic void put_word(input logic [31:0] widx, input logic [31:0] value);
    phys_mem[widx] = value;
    mem_written[widx] = 1'b1;
  endfunction

  // Walks the tables for one request. With commit low the store is left as it
  // is, so the same walk also tells whether every word read was written.
  function automatic rsp_t walk_tables(input req_t r, input bit commit,
                                       output bit reads_ok, output bit builds);
    rsp_t rsp;
    logic [31:0] dir, spare, pde, pte, pte_val, pde_w, pte_w, word_w;
    logic [9:0] pde_i, pte_i;
    int unsigned k;
    rsp = '0;
    rsp.status = ST_OK;
    reads_ok = 1'b1;
    builds = 1'b0;
    dir = dir_base_q & FRAME_MASK;
    spare = r.spare_table_frame & FRAME_MASK;
    pde_i = r.virtual_address[31:22];
    pte_i = r.virtual_address[21:12];
    pde_w = (dir >> 2) + 32'(pde_i);
    pte_val = (r.physical_address & FRAME_MASK) | 32'(r.page_flags) | 32'(PTE_FLAGS);
    word_w = r.physical_address >> 2;
    case (r.operation)
      OP_LOOKUP: begin
        if (pde_w >= STORE_WORDS) begin
          rsp.status = ST_OUTSIDE;
        end else begin
          reads_ok = mem_written[pde_w];
          pde = phys_mem[pde_w];
          if (!pde[ENTRY_PRESENT]) begin
            rsp.status = ST_NOT_MAPPED;
          end else if (pde[ENTRY_LARGE]) begin
            rsp.translated_address = (pde & LARGE_FRAME_MASK) |
                                     (r.virtual_address & LARGE_OFFSET_MASK);
          end else begin
            pte_w = ((pde & FRAME_MASK) >> 2) + 32'(pte_i);
            if (pte_w >= STORE_WORDS) begin
              rsp.status = ST_OUTSIDE;
            end else begin
              reads_ok = reads_ok && mem_written[pte_w];
              pte = phys_mem[pte_w];
              if (!pte[ENTRY_PRESENT]) rsp.status = ST_NOT_MAPPED;
              else rsp.translated_address = pte & FRAME_MASK;
            end
          end
        end
      end
      OP_MAP: begin
        if (pde_i >= USER_DIRECTORY_ENTRIES) begin
          rsp.status = ST_KERNEL;
        end else if (pde_w >= STORE_WORDS) begin
          rsp.status = ST_OUTSIDE;
        end else begin
          reads_ok = mem_written[pde_w];
          pde = phys_mem[pde_w];
          if (!pde[ENTRY_PRESENT]) begin
            if (spare == '0) begin
              rsp.status = ST_NO_SPARE;
            end else if ((spare >> 2) + TABLE_WORDS - 1 >= STORE_WORDS) begin
              rsp.status = ST_OUTSIDE;
            end else begin
              builds = 1'b1;
              if (commit) begin
                for (k = 0; k < TABLE_WORDS; k++) put_word((spare >> 2) + k, '0);
                put_word(pde_w, spare | 32'(PDE_NEW_FLAGS));
                put_word((spare >> 2) + 32'(pte_i), pte_val);
                tables_built++;
              end
            end
          end else begin
            pte_w = ((pde & FRAME_MASK) >> 2) + 32'(pte_i);
            if (pte_w >= STORE_WORDS) rsp.status = ST_OUTSIDE;
            else if (commit) put_word(pte_w, pte_val);
          end
        end
      end
      default: begin
        if (word_w >= STORE_WORDS) begin
          rsp.status = ST_OUTSIDE;
        end else if (r.operation == OP_WRITE) begin
          if (commit) put_word(word_w, r.write_word);
        end else begin
          reads_ok = mem_written[word_w];
          rsp.read_word = phys_mem[word_w];
        end
      end
    endcase
    return rsp;
  endfunction

  function automatic req_t make_req(input logic [1:0] op, input logic [31:0] va,
                                    input logic [31:0] pa, input logic [11:0] flags,
                                    input logic [31:0] spare, input logic [31:0] wdata);
    req_t r;
    r.operation = op;
    r.virtual_address = va;
    r.physical_address = pa;
    r.page_flags = flags;
    r.spare_table_frame = spare;
    r.write_word = wdata;
    return r;
  endfunction

  function automatic logic [31:0] pick_va();
    logic [9:0] dir_i, tab_i;
    case ($urandom_range(3))
      0, 1: dir_i = 10'($urandom_range(7));
      2: dir_i = 10'($urandom_range(771, 764));
      default: dir_i = 10'($urandom());
    endcase
    tab_i = ($urandom_range(3) == 0) ? 10'($urandom()) : 10'($urandom_range(15));
    return {dir_i, tab_i, 12'($urandom())};
  endfunction

  function automatic logic [31:0] in_store_frame();
    return {14'd0, 6'($urandom_range(63, 1)), 12'($urandom())};
  endfunction

  task automatic await_slot();
    while (pending_req.size() != 0 || in_valid) @(negedge clk_i);
  endtask

  task automatic send_request(input req_t r);
    await_slot();
    pending_req.push_back(r);
  endtask

  task automatic send_random();
    req_t r;
    bit reads_ok, builds;
    int unsigned pick, tries;
    logic [31:0] va;
    await_slot();
    for (tries = 0; tries < 24; tries++) begin
      r = make_req(2'($urandom()), pick_va(), $urandom(), 12'($urandom()),
                   in_store_frame(), $urandom());
      pick = $urandom_range(99);
      if (pick < 30) begin
        r.operation = OP_LOOKUP;
        if (mapped_va.size() != 0 && $urandom_range(9) < 6) begin
          va = mapped_va[$urandom_range(mapped_va.size() - 1)];
          r.virtual_address = {va[31:12], 12'($urandom())};
        end
      end else if (pick < 55) begin
        r.operation = OP_MAP;
        case ($urandom_range(9))
          0: r.spare_table_frame = 32'($urandom_range(4095));
          1: r.spare_table_frame = $urandom();
          default: ;
        endcase
      end else begin
        r.operation = (pick < 75) ? OP_WRITE : OP_READ;
        case ($urandom_range(9))
          0: r.physical_address = $urandom();
          1, 2, 3, 4: r.physical_address = ((dir_base_q & FRAME_MASK) +
                                            32'($urandom_range(1023) << 2)) |
                                           32'($urandom_range(3));
          default: r.physical_address = 32'($urandom_range(STORE_WORDS * 4 - 1));
        endcase
        case ($urandom_range(3))
          0: r.write_word = in_store_frame();
          1: r.write_word = in_store_frame() & ~32'h80 | 32'h1;
          default: ;
        endcase
      end
      void'(walk_tables(r, 1'b0, reads_ok, builds));
      if (reads_ok && !(builds && tables_built >= MAX_TABLES)) break;
    end
    if (tries == 24) begin
      r.operation = OP_WRITE;
      r.physical_address = 32'($urandom_range(STORE_WORDS * 4 - 1));
    end
    if (r.operation == OP_MAP) begin
      mapped_va.push_back(r.virtual_address);
      if (mapped_va.size() > 64) void'(mapped_va.pop_front());
    end
    pending_req.push_back(r);
  endtask

  task automatic drain();
    do @(negedge clk_i);
    while (pending_req.size() != 0 || in_valid || expected_rsp.size() != 0);
  endtask

  task automatic write_directory_base(input logic [31:0] value);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= REG_DIRECTORY_BASE;
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i);
    while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    dir_base_q = value;
    @(negedge clk_i);
  endtask

  task automatic run_phase(input logic [31:0] base, input int unsigned count);
    drain();
    write_directory_base(base);
    repeat (count) send_random();
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : drive_requests
    rsp_t predicted;
    bit reads_ok, builds;
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_req <= '0;
      requests_accepted <= 0;
    end else begin
      if (in_valid && !in_stall_o) begin
        predicted = walk_tables(in_req, 1'b1, reads_ok, builds);
        expected_rsp.push_back(predicted);
        requests_accepted <= requests_accepted + 1;
      end
      if (!in_valid || !in_stall_o) begin
        if (pending_req.size() != 0 && (quiet || $urandom_range(99) >= 17)) begin
          in_valid <= 1'b1;
          in_req <= pending_req.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin : hold_off
    if (!rst_ni) begin
      hold_cycles <= 0;
      hold_done <= 1'b0;
    end else if (hold_cycles != 0) begin
      hold_cycles <= hold_cycles - 1;
    end else if (!hold_done && requests_accepted == 120) begin
      hold_cycles <= 400;
      hold_done <= 1'b1;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin : check_responses
    rsp_t want;
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall) begin
        if (expected_rsp.size() == 0) begin
          $error("response with no request outstanding: %p", out_rsp_o);
          failures++;
        end else begin
          want = expected_rsp.pop_front();
          if (out_rsp_o.translated_address !== want.translated_address) begin
            $error("translated_address: expected %h, got %h",
                   want.translated_address, out_rsp_o.translated_address);
            failures++;
          end
          if (out_rsp_o.read_word !== want.read_word) begin
            $error("read_word: expected %h, got %h", want.read_word, out_rsp_o.read_word);
            failures++;
          end
          if (out_rsp_o.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_rsp_o.status);
            failures++;
          end
        end
      end
      if (hold_cycles != 0) out_stall <= 1'b1;
      else out_stall <= !quiet && ($urandom_range(99) < 17);
    end
  end

  initial begin : stimulus
    logic [31:0] full_frame;
    int unsigned frame_no, k;
    bit all_written;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    write_directory_base(32'h0000_0000);
    send_request(make_req(OP_WRITE, 0, 32'h0000_0003, 0, 0, 0));
    send_request(make_req(OP_READ, 0, 32'h0000_0003, 0, 0, 0));
    send_request(make_req(OP_LOOKUP, 32'h0000_0FFF, 0, 0, 0, 0));
    send_request(make_req(OP_MAP, 32'h0000_5000, 0, 0, 0, 0));
    send_request(make_req(OP_MAP, 32'h0000_5000, 0, 0, 32'hFFFF_FFFF, 0));
    send_request(make_req(OP_MAP, 32'hC000_0000, 0, 0, 32'h0000_1000, 0));
    send_request(make_req(OP_MAP, 32'hFFFF_FFFF, 0, 12'hFFF, 32'h0000_1000, 0));
    send_request(make_req(OP_MAP, 32'h0000_5000, 32'hFFFF_FFFF, 12'hFFF, 32'h0000_1FFF, 0));
    send_request(make_req(OP_LOOKUP, 32'h0000_5ABC, 0, 0, 0, 0));
    send_request(make_req(OP_LOOKUP, 32'h0000_6000, 0, 0, 0, 0));
    send_request(make_req(OP_MAP, 32'h0000_6000, 0, 0, 0, 0));
    send_request(make_req(OP_LOOKUP, 32'h0000_6FFF, 0, 0, 0, 0));
    send_request(make_req(OP_WRITE, 0, 32'h0000_0004, 0, 0, 32'h0040_0083));
    send_request(make_req(OP_LOOKUP, 32'h007F_FFFF, 0, 0, 0, 0));
    send_request(make_req(OP_MAP, 32'h0040_1000, 32'h1234_5000, 0, 0, 0));
    send_request(make_req(OP_WRITE, 0, 32'h0000_0008, 0, 0, 32'h0000_2081));
    send_request(make_req(OP_MAP, 32'h0080_3000, 32'hABCD_E000, 12'h002, 0, 0));
    send_request(make_req(OP_READ, 0, 32'h0000_200C, 0, 0, 0));
    send_request(make_req(OP_LOOKUP, 32'h0080_0FFF, 0, 0, 0, 0));
    send_request(make_req(OP_WRITE, 0, 32'h0000_000C, 0, 0, 32'h0050_0001));
    send_request(make_req(OP_LOOKUP, 32'h00C0_0000, 0, 0, 0, 0));
    send_request(make_req(OP_WRITE, 0, 32'h0003_FFFF, 0, 0, 32'hFFFF_FFFF));
    send_request(make_req(OP_READ, 0, 32'h0003_FFFC, 0, 0, 0));
    send_request(make_req(OP_READ, 0, 32'h0004_0000, 0, 0, 0));
    send_request(make_req(OP_WRITE, 0, 32'hFFFF_FFFF, 0, 0, 0));
    run_phase(32'h0000_1ABC, 500);
    run_phase(32'hFFFF_FFFF, 100);
    // The next directory goes on a frame whose every word has been written, else on frame 1.
    full_frame = 32'h0000_1000;
    for (frame_no = 63; frame_no > 1; frame_no--) begin
      all_written = 1'b1;
      for (k = 0; k < TABLE_WORDS; k++) begin
        all_written = all_written && mem_written[frame_no * TABLE_WORDS + k];
      end
      if (all_written) begin
        full_frame = 32'(frame_no) << 12;
        break;
      end
    end
    run_phase(full_frame, 500);
    run_phase(32'h0000_0000, 425);
    drain();
    repeat (1100) @(negedge clk_i);
    if (failures == 0) begin
      $display("PASS two_level_page_table_walker");
    end else begin
      $display("FAIL two_level_page_table_walker");
    end
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("FAIL two_level_page_table_walker");
    $finish;
  end

endmodule
